// ----- hw/rtl/pgcc_pkg.sv -----
// ----------------------------------------------------------------------------
// pgcc_pkg: shared constants, types and tables for the polar grid classifier
// Holds the field widths, fixed-point constants, the CORDIC arctangent
// table, register indexes and the glyph codes.
// ----------------------------------------------------------------------------
package pgcc_pkg;

  localparam int COL_BITS   = 10;
  localparam int ROW_BITS   = 9;
  localparam int ANGLE_BITS = 16;

  localparam int CORDIC_ITERS = 28;
  localparam int FRAC_SHIFT   = 16;

  // Scaled offsets: signed difference times a 4-bit cell size.
  localparam int DX_W = COL_BITS + 1 + 4;
  localparam int DY_W = ROW_BITS + 1 + 4;
  localparam int D_W  = (DX_W > DY_W) ? DX_W : DY_W;
  // CORDIC datapath: offset shifted by 16, plus gain and sign headroom.
  localparam int XY_W = D_W + FRAC_SHIFT + 2;
  localparam int Z_W  = 32;

  localparam logic [29:0] CORDIC_K = 30'd652032874;
  localparam int LO_W   = 16;
  localparam int HI_W   = XY_W - 1 - LO_W;
  localparam int PROD_W = XY_W - 1 + 30;
  localparam int SUM_W  = PROD_W + 1;
  localparam int R_SHIFT = 38;
  localparam int R_W    = SUM_W - R_SHIFT;
  localparam int Q_W    = R_W - 8;

  localparam int REM_BITS   = 4;
  localparam int REM_STAGES = (Q_W + REM_BITS - 1) / REM_BITS;
  localparam int QP_W       = REM_STAGES * REM_BITS;

  localparam int RING_HALF_Q8 = 410;
  localparam int SPOKE_MIN_Q8 = 768;
  localparam longint SPOKE_HALF_Q32 = 64'd68356528;
  localparam int SPOKE_W =
    int'((SPOKE_HALF_Q32 + (64'd1 << (31 - ANGLE_BITS))) >> (32 - ANGLE_BITS));
  localparam int WN_W = ANGLE_BITS + 7;

  localparam logic [2:0] REG_CENTER_COL   = 3'd0;
  localparam logic [2:0] REG_CENTER_ROW   = 3'd1;
  localparam logic [2:0] REG_RING_PITCH   = 3'd2;
  localparam logic [2:0] REG_SPOKE_COUNT  = 3'd3;
  localparam logic [2:0] REG_CELL_WIDTH   = 3'd4;
  localparam logic [2:0] REG_CELL_HEIGHT  = 3'd5;

  typedef enum logic [2:0] {
    GLYPH_BLANK = 3'd0,
    GLYPH_DASH  = 3'd1,
    GLYPH_BACK  = 3'd2,
    GLYPH_BAR   = 3'd3,
    GLYPH_SLASH = 3'd4,
    GLYPH_CROSS = 3'd5
  } glyph_t;

  // atan(2^-i) as a fraction of a full turn, 2^32 per turn.
  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] v;
    case (i)
      0:  v = 32'd536870912;
      1:  v = 32'd316933406;
      2:  v = 32'd167458907;
      3:  v = 32'd85004756;
      4:  v = 32'd42667331;
      5:  v = 32'd21354465;
      6:  v = 32'd10679838;
      7:  v = 32'd5340245;
      8:  v = 32'd2670163;
      9:  v = 32'd1335087;
      10: v = 32'd667544;
      11: v = 32'd333772;
      12: v = 32'd166886;
      13: v = 32'd83443;
      14: v = 32'd41722;
      15: v = 32'd20861;
      16: v = 32'd10430;
      17: v = 32'd5215;
      18: v = 32'd2608;
      19: v = 32'd1304;
      20: v = 32'd652;
      21: v = 32'd326;
      22: v = 32'd163;
      23: v = 32'd81;
      24: v = 32'd41;
      25: v = 32'd20;
      26: v = 32'd10;
      27: v = 32'd5;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  // Four restoring-remainder steps: shift in one quotient bit at a time.
  function automatic logic [6:0] rem_step(input logic [6:0] rem_in,
                                          input logic [REM_BITS-1:0] bits,
                                          input logic [5:0] divisor);
    logic [6:0] r;
    r = rem_in;
    for (int k = REM_BITS - 1; k >= 0; k--) begin
      r = {r[5:0], bits[k]};
      if (r >= {1'b0, divisor}) begin
        r = r - {1'b0, divisor};
      end
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/pgcc_cordic.sv -----
// ----------------------------------------------------------------------------
// pgcc_cordic: pipelined vectoring CORDIC
// Folds the vector into the right half plane, then runs one rotation per
// register stage. Returns the scaled radius, the turn angle and a flag for
// the zero vector.
// ----------------------------------------------------------------------------
module pgcc_cordic
  import pgcc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_v,
  input  logic signed [DX_W-1:0] dx,
  input  logic signed [DY_W-1:0] dy,
  output logic                   out_v,
  output logic [XY_W-2:0]        x_out,
  output logic [Z_W-1:0]         z_out,
  output logic                   zero_out
);

  logic signed [XY_W-1:0] xs [0:CORDIC_ITERS];
  logic signed [XY_W-1:0] ys [0:CORDIC_ITERS];
  logic [Z_W-1:0]         zs [0:CORDIC_ITERS];
  logic                   vs [0:CORDIC_ITERS];
  logic                   zf [0:CORDIC_ITERS];

  logic signed [XY_W-1:0] dx_e;
  logic signed [XY_W-1:0] dy_e;
  logic                   neg;

  assign dx_e = XY_W'(dx);
  assign dy_e = XY_W'(dy);
  assign neg  = dx < 0;

  // Fold into the right half plane, scale to 16 fraction bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      vs[0] <= 1'b0;
    end else if (en) begin
      vs[0] <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0] <= (neg ? -dx_e : dx_e) <<< FRAC_SHIFT;
      ys[0] <= (neg ? -dy_e : dy_e) <<< FRAC_SHIFT;
      zs[0] <= neg ? 32'h8000_0000 : 32'h0;
      zf[0] <= (dx == 0) && (dy == 0);
    end
  end

  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (rst) begin
        vs[i+1] <= 1'b0;
      end else if (en) begin
        vs[i+1] <= vs[i];
      end
    end

    // Rotate toward the x axis; shifts round toward minus infinity.
    always_ff @(posedge clk) begin
      if (en) begin
        zf[i+1] <= zf[i];
        if (ys[i] > 0) begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + atan_turn(i);
        end else begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - atan_turn(i);
        end
      end
    end
  end

  assign out_v    = vs[CORDIC_ITERS];
  assign x_out    = xs[CORDIC_ITERS][XY_W-2:0];
  assign z_out    = zs[CORDIC_ITERS];
  assign zero_out = zf[CORDIC_ITERS];

endmodule

// ----- hw/rtl/polar_grid_cell_classifier_unit.sv -----
// ----------------------------------------------------------------------------
// polar_grid_cell_classifier_unit: ring / spoke glyph classifier per cell
// Pipeline: 34 + REM_STAGES register stages (39 with the default widths):
// offset stage, fold stage, 28 CORDIC stages, two radius multiply stages,
// a spoke stage, the ring remainder stages and the result register.
// Throughput: one request per cycle; the whole pipe holds only while a
// finished result waits at the output and result_ready is low.
// Reset: synchronous, clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module polar_grid_cell_classifier_unit
  import pgcc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  // cell request
  input  logic                item_valid,
  output logic                item_ready,
  input  logic [COL_BITS-1:0] col,
  input  logic [ROW_BITS-1:0] row,
  // classification result
  output logic                result_valid,
  input  logic                result_ready,
  output logic [2:0]          glyph,
  output logic                on_ring,
  output logic                spoke_hit
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [COL_BITS-1:0] center_col;
  logic [ROW_BITS-1:0] center_row;
  logic [5:0]          ring_pitch;
  logic [5:0]          spoke_count;
  logic [3:0]          cell_width;
  logic [3:0]          cell_height;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_col   <= COL_BITS'(40);
      center_row   <= ROW_BITS'(12);
      ring_pitch   <= 6'd20;
      spoke_count  <= 6'd12;
      cell_width   <= 4'd2;
      cell_height  <= 4'd4;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        REG_CENTER_COL:   center_col   <= pwdata[COL_BITS-1:0];
        REG_CENTER_ROW:   center_row   <= pwdata[ROW_BITS-1:0];
        REG_RING_PITCH:   ring_pitch   <= pwdata[5:0];
        REG_SPOKE_COUNT:  spoke_count  <= pwdata[5:0];
        REG_CELL_WIDTH:   cell_width   <= pwdata[3:0];
        REG_CELL_HEIGHT:  cell_height  <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_CENTER_COL:   prdata = 32'(center_col);
      REG_CENTER_ROW:   prdata = 32'(center_row);
      REG_RING_PITCH:   prdata = 32'(ring_pitch);
      REG_SPOKE_COUNT:  prdata = 32'(spoke_count);
      REG_CELL_WIDTH:   prdata = 32'(cell_width);
      REG_CELL_HEIGHT:  prdata = 32'(cell_height);
      default:          prdata = 32'h0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Pipe enable: advance everything unless the result register is stuck.
  // --------------------------------------------------------------------------
  logic en;
  assign en         = !result_valid || result_ready;
  assign item_ready = en;

  // --------------------------------------------------------------------------
  // Offset stage: pixel offsets from the grid centre
  // --------------------------------------------------------------------------
  logic signed [COL_BITS:0] dcol;
  logic signed [ROW_BITS:0] drow;
  logic signed [DX_W-1:0]   dx_c;
  logic signed [DY_W-1:0]   dy_c;
  logic                     v_off;
  logic signed [DX_W-1:0]   dx;
  logic signed [DY_W-1:0]   dy;

  assign dcol = signed'({1'b0, col}) - signed'({1'b0, center_col});
  assign drow = signed'({1'b0, row}) - signed'({1'b0, center_row});
  assign dx_c = dcol * signed'({1'b0, cell_width});
  assign dy_c = drow * signed'({1'b0, cell_height});

  always_ff @(posedge clk) begin
    if (rst) begin
      v_off <= 1'b0;
    end else if (en) begin
      v_off <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx <= dx_c;
      dy <= dy_c;
    end
  end

  // --------------------------------------------------------------------------
  // CORDIC: radius (gain-scaled) and turn angle
  // --------------------------------------------------------------------------
  logic            v_cor;
  logic [XY_W-2:0] x_cor;
  logic [Z_W-1:0]  z_cor;
  logic            zero_cor;

  pgcc_cordic u_cordic (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_v     (v_off),
    .dx       (dx),
    .dy       (dy),
    .out_v    (v_cor),
    .x_out    (x_cor),
    .z_out    (z_cor),
    .zero_out (zero_cor)
  );

  // --------------------------------------------------------------------------
  // Gain correction, split into two partial products; round the angle.
  // --------------------------------------------------------------------------
  logic                  v_pp;
  logic [HI_W+29:0]      pp_hi;
  logic [LO_W+29:0]      pp_lo;
  logic [ANGLE_BITS-1:0] ang_pp;
  logic [Z_W-1:0]        z_rnd;

  assign z_rnd = z_cor + Z_W'(64'd1 << (31 - ANGLE_BITS));

  always_ff @(posedge clk) begin
    if (rst) begin
      v_pp <= 1'b0;
    end else if (en) begin
      v_pp <= v_cor;
    end
  end

  // Zero vector: force angle to zero (radius is already zero).
  always_ff @(posedge clk) begin
    if (en) begin
      pp_hi  <= x_cor[XY_W-2:LO_W] * CORDIC_K;
      pp_lo  <= x_cor[LO_W-1:0] * CORDIC_K;
      ang_pp <= zero_cor ? '0 : z_rnd[Z_W-1:Z_W-ANGLE_BITS];
    end
  end

  // --------------------------------------------------------------------------
  // Radius sum and rounding: 8 fraction bits
  // --------------------------------------------------------------------------
  logic                  v_rad;
  logic [R_W-1:0]        rad;
  logic [ANGLE_BITS-1:0] ang_rad;
  logic [SUM_W-1:0]      rsum;

  assign rsum = SUM_W'({pp_hi, LO_W'(0)}) + SUM_W'(pp_lo)
              + (SUM_W'(1) << (R_SHIFT - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      v_rad <= 1'b0;
    end else if (en) begin
      v_rad <= v_pp;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad     <= rsum[SUM_W-1:R_SHIFT];
      ang_rad <= ang_pp;
    end
  end

  // --------------------------------------------------------------------------
  // Spoke test and glyph sector
  // --------------------------------------------------------------------------
  logic [ANGLE_BITS+5:0]        a_n;
  logic [ANGLE_BITS-1:0]        sp_pos;
  logic [WN_W-1:0]              wn;
  logic signed [ANGLE_BITS+7:0] sp_lim;
  logic                         spoke_c;

  always_comb begin
    a_n     = ang_rad * spoke_count;
    sp_pos  = a_n[ANGLE_BITS-1:0];
    wn      = WN_W'(SPOKE_W) * spoke_count;
    sp_lim  = signed'((ANGLE_BITS+8)'(1) << ANGLE_BITS) - signed'((ANGLE_BITS+8)'(wn));
    spoke_c = (spoke_count != 6'd0) && (rad > R_W'(SPOKE_MIN_Q8))
            && ((WN_W'(sp_pos) < wn)
                || (signed'((ANGLE_BITS+8)'(sp_pos)) > sp_lim));
  end

  // Remainder pipe arrays; index 0 is the spoke stage.
  logic                v_rm   [0:REM_STAGES];
  logic [6:0]          rem    [0:REM_STAGES];
  logic [QP_W-1:0]     q_rm   [0:REM_STAGES];
  logic [7:0]          rlo_rm [0:REM_STAGES];
  logic                spk_rm [0:REM_STAGES];
  logic [2:0]          sec_rm [0:REM_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      v_rm[0] <= 1'b0;
    end else if (en) begin
      v_rm[0] <= v_rad;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]    <= 7'd0;
      q_rm[0]   <= QP_W'(rad[R_W-1:8]);
      rlo_rm[0] <= rad[7:0];
      spk_rm[0] <= spoke_c;
      sec_rm[0] <= ang_rad[ANGLE_BITS-2:ANGLE_BITS-4];
    end
  end

  // --------------------------------------------------------------------------
  // Ring remainder: (radius >> 8) mod ring_pitch, four bits a stage
  // --------------------------------------------------------------------------
  for (genvar k = 0; k < REM_STAGES; k++) begin : g_rem
    always_ff @(posedge clk) begin
      if (rst) begin
        v_rm[k+1] <= 1'b0;
      end else if (en) begin
        v_rm[k+1] <= v_rm[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]    <= rem_step(rem[k],
                                q_rm[k][QP_W-1-REM_BITS*k -: REM_BITS],
                                ring_pitch);
        q_rm[k+1]   <= q_rm[k];
        rlo_rm[k+1] <= rlo_rm[k];
        spk_rm[k+1] <= spk_rm[k];
        sec_rm[k+1] <= sec_rm[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Ring decision, glyph choice and result register
  // --------------------------------------------------------------------------
  logic signed [15:0] ring_pos;
  logic signed [15:0] ring_span;
  logic               ring_c;
  logic               spk_f;
  glyph_t             glyph_c;

  always_comb begin
    ring_pos  = signed'({2'b00, rem[REM_STAGES][5:0], rlo_rm[REM_STAGES]});
    ring_span = signed'({2'b00, ring_pitch, 8'd0});
    ring_c    = (ring_pitch != 6'd0)
              && ((ring_pos < 16'sd410) || (ring_pos > ring_span - 16'sd410));
    spk_f     = spk_rm[REM_STAGES];
    if (!ring_c && !spk_f) begin
      glyph_c = GLYPH_BLANK;
    end else if (ring_c && spk_f) begin
      glyph_c = GLYPH_CROSS;
    end else begin
      // Angle folded to a half turn, eight sixteenth-turn sectors.
      case (sec_rm[REM_STAGES])
        3'd0, 3'd7: glyph_c = GLYPH_DASH;
        3'd1, 3'd2: glyph_c = GLYPH_BACK;
        3'd3, 3'd4: glyph_c = GLYPH_BAR;
        default:    glyph_c = GLYPH_SLASH;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= v_rm[REM_STAGES];
    end
  end

  // Hold the result while the consumer stalls.
  always_ff @(posedge clk) begin
    if (en) begin
      glyph     <= glyph_c;
      on_ring   <= ring_c;
      spoke_hit <= spk_f;
    end
  end

endmodule
